@@ rtl/five_tuple_flow_packet_counter_top_macros.svh @@
// Assertion macros for the five-tuple flow counter checker.
// Included by the checker file; no other dependencies.
`ifndef FIVE_TUPLE_FLOW_PACKET_COUNTER_TOP_MACROS_SVH
`define FIVE_TUPLE_FLOW_PACKET_COUNTER_TOP_MACROS_SVH
// Assert that a property holds on every clock while out of reset.
`define FTC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert that a property holds also during reset.
`define FTC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ rtl/ftc_pkg.sv @@
// Package for the five-tuple flow counter: outcome codes, key type, protocol constants.
// No dependencies.
`timescale 1ns / 1ps
package ftc_pkg;
  typedef enum logic [1:0] {
    OUT_IGNORED = 2'd0,
    OUT_NEW     = 2'd1,
    OUT_HIT     = 2'd2,
    OUT_FULL    = 2'd3
  } outcome_e;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  typedef struct packed {
    logic [63:0] addr;
    logic [39:0] pp;
  } key_t;

  // Lookup token travelling along the cell row.
  typedef struct packed {
    logic        active;
    logic        ingress;
    key_t        key;
    logic        hit;
    logic        free_found;
    logic [7:0]  free_idx;
    logic [3:0]  idx;
    logic [31:0] in_tot;
    logic [31:0] eg_tot;
  } token_t;

  typedef enum logic [1:0] {
    ST_PARSE = 2'd0,
    ST_SEARCH = 2'd1,
    ST_CLAIM = 2'd2,
    ST_OUT = 2'd3
  } state_e;
endpackage

@@ rtl/ftc_if.sv @@
// Valid/ready channel interfaces for the five-tuple flow counter.
// Depends on nothing.
`timescale 1ns / 1ps
interface ftc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last_byte;
  logic       count_as_ingress;
  modport source (output valid, packet_byte, last_byte, count_as_ingress, input ready);
  modport sink   (input valid, packet_byte, last_byte, count_as_ingress, output ready);
endinterface

interface ftc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  outcome;
  logic [3:0]  entry_index;
  logic [31:0] ingress_total;
  logic [31:0] egress_total;
  modport source (output valid, outcome, entry_index, ingress_total, egress_total,
                  input ready);
  modport sink   (input valid, outcome, entry_index, ingress_total, egress_total,
                  output ready);
endinterface

@@ rtl/ftc_cell.sv @@
// One flow table slot: holds key and counters, inspects the passing token.
// Depends on ftc_pkg.
`timescale 1ns / 1ps
module ftc_cell #(
  parameter int Index = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ftc_pkg::token_t tok_i,
  input  logic            claim_i,
  input  ftc_pkg::key_t   claim_key_i,
  input  logic            claim_ingress_i,
  output ftc_pkg::token_t tok_o
);
  import ftc_pkg::*;

  logic        valid_q;
  key_t        key_q;
  logic [31:0] in_q, eg_q;
  logic        match;
  token_t      tok_d, tok_q;

  assign match = tok_i.active && valid_q && !tok_i.hit && (key_q == tok_i.key);

  always_comb begin
    tok_d = tok_i;
    if (match) begin
      tok_d.hit    = 1'b1;
      tok_d.idx    = 4'(Index);
      tok_d.in_tot = tok_i.ingress ? in_q + 32'd1 : in_q;
      tok_d.eg_tot = tok_i.ingress ? eg_q : eg_q + 32'd1;
    end else if (tok_i.active && !valid_q && !tok_i.free_found) begin
      tok_d.free_found = 1'b1;
      tok_d.free_idx   = 8'(Index);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (claim_i) valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (claim_i) begin
      key_q <= claim_key_i;
      in_q  <= {31'd0, claim_ingress_i};
      eg_q  <= {31'd0, !claim_ingress_i};
    end else if (match) begin
      in_q <= tok_d.in_tot;
      eg_q <= tok_d.eg_tot;
    end
  end

  assign tok_o = tok_q;
endmodule

@@ rtl/ftc_parser.sv @@
// Header capture: byte offset counter and fixed-offset field registers.
// Depends on ftc_pkg.
`timescale 1ns / 1ps
module ftc_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  input  logic          ingress_i,
  output logic          done_o,
  output logic          keep_o,
  output ftc_pkg::key_t key_o
);
  import ftc_pkg::*;

  logic [5:0]  off_q;
  logic [15:0] et_q;
  logic [7:0]  pr_q;
  logic [63:0] ad_q;
  logic [31:0] po_q;
  logic [15:0] et_n;
  logic [7:0]  pr_n;
  logic [63:0] ad_n, ad_k;
  logic [31:0] po_n, po_k;
  logic [6:0]  len;
  logic        ok;

  always_comb begin
    et_n = et_q; pr_n = pr_q; ad_n = ad_q; po_n = po_q;
    if (off_q == 6'd12 || off_q == 6'd13) et_n = {et_q[7:0], byte_i};
    if (off_q == 6'd23) pr_n = byte_i;
    if (off_q >= 6'd26 && off_q <= 6'd33) ad_n = {ad_q[55:0], byte_i};
    if (off_q >= 6'd34 && off_q <= 6'd37) po_n = {po_q[23:0], byte_i};
    len = {1'b0, off_q} + 7'd1;
    ok  = (et_n == ETHERTYPE_IPV4) && (len >= 7'd34) &&
          ((pr_n == PROTO_TCP && len >= 7'd54) || (pr_n == PROTO_UDP && len >= 7'd42) ||
           pr_n == PROTO_ICMP);
    po_k = (pr_n == PROTO_ICMP) ? 32'd0 : po_n;
    ad_k = ad_n;
    if (!ingress_i) begin
      ad_k = {ad_n[31:0], ad_n[63:32]};
      po_k = {po_k[15:0], po_k[31:16]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0; et_q <= '0; pr_q <= '0; ad_q <= '0; po_q <= '0;
      done_o <= 1'b0; keep_o <= 1'b0;
      key_o  <= '0;
    end else begin
      done_o <= take_i && last_i;
      if (take_i) begin
        et_q <= et_n; pr_q <= pr_n; ad_q <= ad_n; po_q <= po_n;
        keep_o <= ok;
        key_o  <= '{addr: ad_k, pp: {po_k, pr_n}};
        if (last_i) off_q <= '0;
        else if (off_q != 6'd63) off_q <= off_q + 6'd1;
      end
    end
  end
endmodule

@@ rtl/five_tuple_flow_packet_counter_top.sv @@
// Top level of the five-tuple flow counter: parser, cell row and result register.
// Depends on ftc_pkg, ftc_if, ftc_parser and ftc_cell.
//
//   channel | dir | payload
//   in_ch   | in  | packet_byte, last_byte, count_as_ingress
//   out_ch  | out | outcome, entry_index, ingress_total, egress_total
//
// Bytes are taken one per cycle while input ready is high. On the last byte of a
// counted frame, the key walks the row of TABLE_ENTRIES cells, one cell per cycle;
// then a claim state claims a free slot on a miss and the result is offered. An
// ignored frame skips the walk and the claim and goes straight to the result.
// Input ready is low from the last byte until the result is taken. Reset empties
// the table at once (valid bits only).
`timescale 1ns / 1ps
module five_tuple_flow_packet_counter_top #(
  parameter int TABLE_ENTRIES = 16
) (
  input logic clk_i,
  input logic rst_ni,
  ftc_in_if.sink    in_ch,
  ftc_out_if.source out_ch
);
  import ftc_pkg::*;

  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  state_e state_q, state_d;
  logic   done, keep;
  key_t   key;
  logic   ingress_q;
  token_t tok [TABLE_ENTRIES+1];
  token_t res_q;
  logic [CW-1:0] cnt_q;
  logic [TABLE_ENTRIES-1:0] claim;

  assign in_ch.ready = (state_q == ST_PARSE) && !done;

  ftc_parser u_parser (
    .clk_i, .rst_ni,
    .take_i(in_ch.valid && in_ch.ready), .byte_i(in_ch.packet_byte),
    .last_i(in_ch.last_byte), .ingress_i(in_ch.count_as_ingress),
    .done_o(done), .keep_o(keep), .key_o(key)
  );

  // Capture the direction with the last byte.
  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready && in_ch.last_byte) ingress_q <= in_ch.count_as_ingress;
  end

  // Launch a token into the row when a kept frame ends.
  always_comb begin
    tok[0] = '0;
    tok[0].active  = done && keep;
    tok[0].ingress = ingress_q;
    tok[0].key     = key;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    assign claim[g] = (state_q == ST_CLAIM) && res_q.active && !res_q.hit &&
                      res_q.free_found && (res_q.free_idx == 8'(g));
    ftc_cell #(.Index(g)) u_cell (
      .clk_i, .rst_ni, .tok_i(tok[g]), .claim_i(claim[g]),
      .claim_key_i(res_q.key), .claim_ingress_i(res_q.ingress), .tok_o(tok[g+1])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_PARSE:  if (done) state_d = keep ? ST_SEARCH : ST_OUT;
      ST_SEARCH: if (cnt_q == CW'(TABLE_ENTRIES)) state_d = ST_CLAIM;
      ST_CLAIM:  state_d = ST_OUT;
      ST_OUT:    if (out_ch.ready) state_d = ST_PARSE;
      default:   state_d = ST_PARSE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_PARSE;
      cnt_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PARSE) begin
        cnt_q <= CW'(1);
        res_q <= '0;
      end else if (state_q == ST_SEARCH) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(TABLE_ENTRIES)) res_q <= tok[TABLE_ENTRIES];
      end
    end
  end

  // Drive the result from the collected token.
  always_comb begin
    out_ch.valid         = (state_q == ST_OUT);
    out_ch.outcome       = OUT_IGNORED;
    out_ch.entry_index   = '0;
    out_ch.ingress_total = '0;
    out_ch.egress_total  = '0;
    if (res_q.active) begin
      if (res_q.hit) begin
        out_ch.outcome       = OUT_HIT;
        out_ch.entry_index   = res_q.idx;
        out_ch.ingress_total = res_q.in_tot;
        out_ch.egress_total  = res_q.eg_tot;
      end else if (res_q.free_found) begin
        out_ch.outcome       = OUT_NEW;
        out_ch.entry_index   = res_q.free_idx[3:0];
        out_ch.ingress_total = {31'd0, res_q.ingress};
        out_ch.egress_total  = {31'd0, !res_q.ingress};
      end else begin
        out_ch.outcome = OUT_FULL;
      end
    end
  end
endmodule

@@ rtl/ftc_checker.sv @@
// Port-level checker for the five-tuple flow counter, bound to the top level.
// Depends on ftc_pkg and the macro header.
`timescale 1ns / 1ps
`include "five_tuple_flow_packet_counter_top_macros.svh"
module ftc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  outcome,
  input logic [3:0]  entry_index,
  input logic [31:0] ingress_total
);
  import ftc_pkg::*;
  `FTC_ASSERT(a_no_overlap, clk_i, rst_ni, out_valid |-> !in_ready, "input taken while result pending")
  `FTC_ASSERT(a_stall_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid && $stable(outcome), "result dropped")
  `FTC_ASSERT(a_last_stops, clk_i, rst_ni, in_valid && in_ready && in_last |=> !in_ready, "accepted past frame end")
  `FTC_ASSERT(a_idx_zero, clk_i, rst_ni, out_valid && (outcome == OUT_IGNORED || outcome == OUT_FULL) |-> entry_index == 4'd0 && ingress_total == 32'd0, "index on miss")
  `FTC_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid, "result during reset")
endmodule

bind five_tuple_flow_packet_counter_top ftc_checker u_ftc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.last_byte),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .outcome(out_ch.outcome),
  .entry_index(out_ch.entry_index), .ingress_total(out_ch.ingress_total)
);
